// ----- src/lsfd_pkg.sv -----
package lsfd_pkg;

   // Fixed field widths
   localparam int COVER_W     = 8;
   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 8;
   localparam int HDR_CNT_W   = 6;
   localparam int BIT_CNT_W   = 5;
   localparam int LEN_W       = 32;
   localparam int PASSKEY_W   = 64;
   localparam int PKLEN_W     = 4;
   localparam int MIDX_W      = 3;
   localparam int CSR_IDX_W   = 1;

   // Defaults for top-level parameters
   localparam int DEF_HEADER_BYTES = 54;
   localparam int DEF_PASSKEY_MAX  = 8;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_EXT      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DATA     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MISMATCH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PASSKEY_VALUE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSKEY_LENGTH = 1'd1;

   typedef struct packed {
      logic [COVER_W-1:0] cover_byte;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [PASSKEY_W-1:0] wdata;
   } csr_write_type;

endpackage

// ----- src/lsb_stego_frame_decoder_unit.sv -----
// A result word is registered in the output register, or in the skid entry while rsp stalls.
// Throughput: one cover byte per cycle while req_stall is low; each byte is at most one shift and counter update.
// A two-entry result buffer (output register plus skid) stalls req only while both
// entries hold words not yet taken.
// Reset (synchronous, active high) clears the decoder to idle and zeroes the passkey.
module lsb_stego_frame_decoder_unit #(
   parameter int HEADER_BYTES = lsfd_pkg::DEF_HEADER_BYTES,
   parameter int PASSKEY_MAX  = lsfd_pkg::DEF_PASSKEY_MAX
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [lsfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsfd_pkg::PASSKEY_W-1:0]       csr_wdata,
   // cover bytes in
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lsfd_pkg::req_type                    req_payload,
   // decoded words out
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lsfd_pkg::rsp_type                    rsp_payload
);
   import lsfd_pkg::*;

   csr_write_type csr;
   logic          accept;
   logic          res_valid;
   rsp_type       res;

   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_type       skid_ff, skid_in;
   logic          take;

   assign csr = '{we: csr_we, index: csr_index, wdata: csr_wdata};

   // Input is held off only when the skid entry is occupied, so req_stall
   // is a plain register output.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   lsfd_core #(
      .HEADER_BYTES (HEADER_BYTES),
      .PASSKEY_MAX  (PASSKEY_MAX)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .accept    (accept),
      .req       (req_payload),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result buffer: the output register drains first, the skid entry refills it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no new word can arrive while the skid entry is full
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ----- src/lsfd_core.sv -----
module lsfd_core #(
   parameter int HEADER_BYTES = 54,
   parameter int PASSKEY_MAX  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lsfd_pkg::csr_write_type csr,
   input  logic                   accept,
   input  lsfd_pkg::req_type      req,
   output logic                   res_valid,
   output lsfd_pkg::rsp_type      res
);
   import lsfd_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_MLEN   = 3'd2;
   localparam logic [2:0] PH_MBYTES = 3'd3;
   localparam logic [2:0] PH_XLEN   = 3'd4;
   localparam logic [2:0] PH_XBYTES = 3'd5;
   localparam logic [2:0] PH_DLEN   = 3'd6;
   localparam logic [2:0] PH_DBYTES = 3'd7;

   localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(HEADER_BYTES);
   localparam logic [PKLEN_W-1:0]   PK_LIMIT  = PKLEN_W'(PASSKEY_MAX);

   logic [PASSKEY_W-1:0] pk_value_ff;
   logic [PKLEN_W-1:0]   pk_len_ff;

   logic [2:0]           phase_ff, phase_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]     acc_ff, acc_in;
   logic [LEN_W-1:0]     remain_ff, remain_in;
   logic [MIDX_W-1:0]    midx_ff, midx_in;
   logic                 mism_ff, mism_in;

   always_comb begin
      logic [2:0]           ph;
      logic [2:0]           phw;
      logic [HDR_CNT_W-1:0] hc;
      logic [BIT_CNT_W-1:0] bc;
      logic [LEN_W-1:0]     acc;
      logic [LEN_W-1:0]     rem;
      logic [LEN_W-1:0]     rem_dec;
      logic [MIDX_W-1:0]    mi;
      logic                 ms;
      logic [LEN_W-1:0]     word;
      logic [VALUE_W-1:0]   b;
      logic [VALUE_W-1:0]   expected;
      logic                 is_len;
      logic                 word_done;
      logic                 ms_any;

      // frame start restarts from a clean header state
      ph  = req.frame_start ? PH_HEADER : phase_ff;
      hc  = req.frame_start ? '0 : hdr_cnt_ff;
      bc  = req.frame_start ? '0 : bit_cnt_ff;
      acc = req.frame_start ? '0 : acc_ff;
      rem = req.frame_start ? '0 : remain_ff;
      mi  = req.frame_start ? '0 : midx_ff;
      ms  = req.frame_start ? 1'b0 : mism_ff;

      phase_in   = ph;
      hdr_cnt_in = hc;
      bit_cnt_in = bc;
      acc_in     = acc;
      remain_in  = rem;
      midx_in    = mi;
      mism_in    = ms;
      res_valid  = 1'b0;
      res        = '{kind: KIND_EXT, value: '0, last: 1'b0};

      phw       = (ph == PH_HEADER) ? PH_MLEN : ph;
      word      = {acc[LEN_W-2:0], req.cover_byte[0]};
      b         = word[VALUE_W-1:0];
      rem_dec   = rem - LEN_W'(1);
      expected  = pk_value_ff[{mi, 3'b000} +: VALUE_W];
      ms_any    = ms | (b != expected);
      is_len    = (phw == PH_MLEN) || (phw == PH_XLEN) || (phw == PH_DLEN);
      word_done = is_len ? (bc == BIT_CNT_W'(LEN_W - 1)) : (bc == BIT_CNT_W'(VALUE_W - 1));

      if (ph == PH_IDLE) begin
         phase_in = PH_IDLE;
      end else if (ph == PH_HEADER && hc < HDR_LIMIT) begin
         hdr_cnt_in = hc + HDR_CNT_W'(1);
      end else if (!word_done) begin
         phase_in   = phw;
         bit_cnt_in = bc + BIT_CNT_W'(1);
         acc_in     = word;
      end else begin
         phase_in   = phw;
         bit_cnt_in = '0;
         acc_in     = '0;
         unique case (phw)
            PH_MLEN: begin
               if (pk_len_ff > PK_LIMIT || word != LEN_W'(pk_len_ff)) begin
                  mism_in   = 1'b1;
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res       = '{kind: KIND_MISMATCH, value: '0, last: 1'b1};
               end else if (word == '0) begin
                  phase_in  = PH_XLEN;
                  res_valid = 1'b1;
                  res       = '{kind: KIND_MATCH, value: '0, last: 1'b0};
               end else begin
                  remain_in = word;
                  midx_in   = '0;
                  phase_in  = PH_MBYTES;
               end
            end
            PH_MBYTES: begin
               mism_in   = ms_any;
               midx_in   = mi + MIDX_W'(1);
               remain_in = rem_dec;
               if (rem_dec == '0) begin
                  res_valid = 1'b1;
                  if (ms_any) begin
                     phase_in = PH_IDLE;
                     res      = '{kind: KIND_MISMATCH, value: '0, last: 1'b1};
                  end else begin
                     phase_in = PH_XLEN;
                     res      = '{kind: KIND_MATCH, value: '0, last: 1'b0};
                  end
               end
            end
            PH_XLEN: begin
               if (word == '0) begin
                  phase_in = PH_DLEN;
               end else begin
                  remain_in = word;
                  phase_in  = PH_XBYTES;
               end
            end
            PH_XBYTES: begin
               remain_in = rem_dec;
               if (rem_dec == '0) phase_in = PH_DLEN;
               res_valid = 1'b1;
               res       = '{kind: KIND_EXT, value: b, last: 1'b0};
            end
            PH_DLEN: begin
               if (word == '0) begin
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res       = '{kind: KIND_EMPTY, value: '0, last: 1'b1};
               end else begin
                  remain_in = word;
                  phase_in  = PH_DBYTES;
               end
            end
            PH_DBYTES: begin
               remain_in = rem_dec;
               res_valid = 1'b1;
               if (rem_dec == '0) begin
                  phase_in = PH_IDLE;
                  res      = '{kind: KIND_DATA, value: b, last: 1'b1};
               end else begin
                  res      = '{kind: KIND_DATA, value: b, last: 1'b0};
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (!accept) res_valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_value_ff <= '0;
         pk_len_ff   <= '0;
      end else if (csr.we) begin
         unique case (csr.index)
            CSR_PASSKEY_VALUE:  pk_value_ff <= csr.wdata;
            CSR_PASSKEY_LENGTH: pk_len_ff   <= csr.wdata[PKLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hdr_cnt_ff <= '0;
         bit_cnt_ff <= '0;
         acc_ff     <= '0;
         remain_ff  <= '0;
         midx_ff    <= '0;
         mism_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         bit_cnt_ff <= bit_cnt_in;
         acc_ff     <= acc_in;
         remain_ff  <= remain_in;
         midx_ff    <= midx_in;
         mism_ff    <= mism_in;
      end
   end

endmodule

// ----- src/lsfd_checker.sv -----
module lsfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lsfd_pkg::rsp_type rsp_payload
);
   import lsfd_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp word changed while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // status kinds carry no byte
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_MATCH || rsp_payload.kind == KIND_MISMATCH ||
                    rsp_payload.kind == KIND_EMPTY) |-> rsp_payload.value == '0)
      else $error("status word with nonzero value");

   // mismatch and empty data always end the frame
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_MISMATCH || rsp_payload.kind == KIND_EMPTY)
      |-> rsp_payload.last)
      else $error("terminal word without last");

   // extension bytes and a match never end the frame
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_EXT || rsp_payload.kind == KIND_MATCH)
      |-> !rsp_payload.last)
      else $error("last set on non-terminal word");

endmodule

bind lsb_stego_frame_decoder_unit lsfd_checker u_lsfd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
